// ----- hw/rtl/sva_pkg.sv -----
// Shared types and constants for the synth voice allocator.
// No dependencies; used by the controller, the datapath and the top level.
package sva_pkg;

   localparam int MAX_VOICES_DEF    = 18;
   localparam int MIDI_CHANNELS_DEF = 16;

   localparam logic [4:0] VOICE_COUNT_RESET = 5'd9;
   localparam logic [6:0] PEDAL_LEVEL       = 7'h40;
   localparam logic [6:0] VIBRATO_LEVEL     = 7'd40;

   localparam logic [2:0] MODE_ALLOC    = 3'd0;
   localparam logic [2:0] MODE_RELEASE  = 3'd1;
   localparam logic [2:0] MODE_PEDAL    = 3'd2;
   localparam logic [2:0] MODE_MODULATE = 3'd3;
   localparam logic [2:0] MODE_TOUCH    = 3'd4;
   localparam logic [2:0] MODE_STOP_ALL = 3'd5;

   localparam logic [2:0] EV_NONE         = 3'd0;
   localparam logic [2:0] EV_ALLOC_FREE   = 3'd1;
   localparam logic [2:0] EV_ALLOC_STOLEN = 3'd2;
   localparam logic [2:0] EV_RELEASED     = 3'd3;
   localparam logic [2:0] EV_SUSTAINED    = 3'd4;
   localparam logic [2:0] EV_VIB_ON       = 3'd5;
   localparam logic [2:0] EV_VIB_OFF      = 3'd6;
   localparam logic [2:0] EV_TOUCHED      = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SEARCH,
      ST_STEAL,
      ST_ALLOC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_idx;
      logic scan;
      logic search;
      logic steal;
      logic alloc;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic no_steal;
      logic idx_last;
      logic search_hit;
      logic steal_hit;
      logic old_ok;
   } status_type;

endpackage

// ----- hw/rtl/sva_ctrl.sv -----
// Sequencer of the voice allocator: walks scan, search and steal phases.
// Depends on sva_pkg; drives the datapath by command and reads its status.
module sva_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sva_pkg::status_type status,
   output sva_pkg::cmd_type    cmd
);
   import sva_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (start) state_in = ST_DISPATCH;
         ST_DISPATCH: state_in = status.is_alloc ? ST_SEARCH : ST_SCAN;
         ST_SCAN:     if (status.idx_last) state_in = ST_FINISH;
         ST_SEARCH: begin
            if (status.search_hit)    state_in = ST_ALLOC;
            else if (status.idx_last) state_in = status.no_steal ? ST_FINISH : ST_STEAL;
         end
         ST_STEAL: begin
            if (status.steal_hit)     state_in = ST_ALLOC;
            else if (status.idx_last) state_in = status.old_ok ? ST_ALLOC : ST_FINISH;
         end
         ST_ALLOC:    state_in = ST_IDLE;
         ST_FINISH:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE:   cmd.load = start;
         ST_SCAN:   cmd.scan = 1'b1;
         ST_SEARCH: begin
            cmd.search    = 1'b1;
            cmd.clear_idx = status.idx_last & ~status.search_hit;
         end
         ST_STEAL:  cmd.steal = 1'b1;
         ST_ALLOC:  cmd.alloc = 1'b1;
         ST_FINISH: cmd.finish = 1'b1;
         default:   cmd = '0;
      endcase
   end

endmodule

// ----- hw/rtl/sva_dp.sv -----
// Datapath of the voice allocator: voice table, channel flags, search
// pointer and result register. Depends on sva_pkg; commanded by sva_ctrl.
module sva_dp #(
   parameter int MAX_VOICES    = sva_pkg::MAX_VOICES_DEF,
   parameter int MIDI_CHANNELS = sva_pkg::MIDI_CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  sva_pkg::cmd_type    cmd,
   output sva_pkg::status_type status,
   input  logic [2:0]         req_mode,
   input  logic [3:0]         req_midi_channel,
   input  logic [6:0]         req_note,
   input  logic               req_secondary,
   input  logic               req_no_search_past_free,
   input  logic               req_no_kill_oldest,
   input  logic [6:0]         req_value,
   input  logic [31:0]        req_now,
   input  logic               csr_valid,
   input  logic [4:0]         csr_voice_count,
   output logic               rsp_valid,
   output logic [4:0]         rsp_voice,
   output logic [2:0]         rsp_event_res,
   output logic               rsp_last
);
   import sva_pkg::*;

   localparam int IW  = $clog2(MAX_VOICES);
   localparam int CHW = (MIDI_CHANNELS > 1) ? $clog2(MIDI_CHANNELS) : 1;
   localparam logic [5:0]    MAXV     = 6'(MAX_VOICES);
   localparam logic [IW-1:0] PTR_INIT = IW'(MAX_VOICES - 1);

   logic          free_ff  [MAX_VOICES];
   logic          sec_ff   [MAX_VOICES];
   logic          sus_ff   [MAX_VOICES];
   logic          vib_ff   [MAX_VOICES];
   logic [3:0]    owner_ff [MAX_VOICES];
   logic [6:0]    note_ff  [MAX_VOICES];
   logic [31:0]   time_ff  [MAX_VOICES];
   logic          pedal_ff [MIDI_CHANNELS];
   logic          wantv_ff [MIDI_CHANNELS];

   logic [4:0]    count_ff;
   logic [IW-1:0] ptr_ff, idx_ff, sel_ff;
   logic [2:0]    mode_ff;
   logic [3:0]    ch_ff;
   logic [6:0]    rnote_ff;
   logic          rsec_ff, nosteal_ff, noold_ff, pedal_on_ff, vib_on_ff;
   logic [31:0]   now_ff, old_time_ff;
   logic          have_old_ff, stolen_ff;
   logic          pend_v_ff;
   logic [IW-1:0] pend_voice_ff;
   logic [2:0]    pend_ev_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   logic [4:0]    rsp_voice_ff;
   logic [2:0]    rsp_ev_ff;

   logic [5:0]    n_eff;
   logic [IW-1:0] nlast, nxt;
   logic          ch_ok, busy_v, own, match;
   logic [2:0]    ev;
   logic          do_free, do_sus, do_stamp, do_vib;
   logic [CHW-1:0] chi;
   logic          cand;

   always_comb begin
      if (count_ff == 5'd0)             n_eff = 6'd1;
      else if ({1'b0, count_ff} > MAXV) n_eff = MAXV;
      else                              n_eff = {1'b0, count_ff};
   end
   assign nlast = IW'(n_eff - 6'd1);
   assign nxt   = (ptr_ff >= nlast) ? '0 : ptr_ff + 1'b1;
   assign chi   = ch_ff[CHW-1:0];
   assign ch_ok = {1'b0, ch_ff} < 5'(MIDI_CHANNELS);
   assign busy_v = ~free_ff[idx_ff];
   assign own    = owner_ff[idx_ff] == ch_ff;
   assign cand   = time_ff[idx_ff] < old_time_ff;

   always_comb begin
      match = 1'b0; ev = EV_NONE;
      do_free = 1'b0; do_sus = 1'b0; do_stamp = 1'b0; do_vib = 1'b0;
      case (mode_ff)
         MODE_STOP_ALL: if (busy_v) begin
            match = 1'b1; ev = EV_RELEASED; do_free = 1'b1;
         end
         MODE_RELEASE: if (ch_ok && busy_v && own && note_ff[idx_ff] == rnote_ff) begin
            match = 1'b1;
            if (pedal_ff[chi]) begin ev = EV_SUSTAINED; do_sus = 1'b1; end
            else begin ev = EV_RELEASED; do_free = 1'b1; end
         end
         MODE_PEDAL: if (ch_ok && !pedal_on_ff && busy_v && own && sus_ff[idx_ff]) begin
            match = 1'b1; ev = EV_RELEASED; do_free = 1'b1;
         end
         MODE_MODULATE: if (ch_ok && busy_v && own) begin
            do_stamp = 1'b1;
            if (vib_ff[idx_ff] != vib_on_ff) begin
               match = 1'b1; do_vib = 1'b1;
               ev = vib_on_ff ? EV_VIB_ON : EV_VIB_OFF;
            end
         end
         MODE_TOUCH: if (ch_ok && busy_v && own) begin
            match = 1'b1; ev = EV_TOUCHED; do_stamp = 1'b1;
         end
         default: match = 1'b0;
      endcase
   end

   assign status.is_alloc   = (mode_ff == MODE_ALLOC) && ch_ok;
   assign status.no_steal   = nosteal_ff;
   assign status.idx_last   = idx_ff == nlast;
   assign status.search_hit = free_ff[nxt];
   assign status.steal_hit  = sec_ff[idx_ff];
   assign status.old_ok     = ~noold_ff & (have_old_ff | cand);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VOICES; i++) begin
            free_ff[i]  <= 1'b1;
            sec_ff[i]   <= 1'b1;
            sus_ff[i]   <= 1'b1;
            vib_ff[i]   <= 1'b1;
            owner_ff[i] <= 4'hF;
            note_ff[i]  <= 7'h7F;
            time_ff[i]  <= 32'hFFFF_FFFF;
         end
         for (int c = 0; c < MIDI_CHANNELS; c++) begin
            pedal_ff[c] <= 1'b0;
            wantv_ff[c] <= 1'b0;
         end
         count_ff     <= VOICE_COUNT_RESET;
         ptr_ff       <= PTR_INIT;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.alloc | cmd.finish | (cmd.scan & match & pend_v_ff);
         if (csr_valid) count_ff <= csr_voice_count;

         if (cmd.load) begin
            mode_ff     <= req_mode;
            ch_ff       <= req_midi_channel;
            rnote_ff    <= req_note;
            rsec_ff     <= req_secondary;
            nosteal_ff  <= req_no_search_past_free;
            noold_ff    <= req_no_kill_oldest;
            pedal_on_ff <= req_value >= PEDAL_LEVEL;
            vib_on_ff   <= req_value >= VIBRATO_LEVEL;
            now_ff      <= req_now;
            old_time_ff <= req_now;
            have_old_ff <= 1'b0;
            stolen_ff   <= 1'b0;
            idx_ff      <= '0;
            pend_v_ff   <= 1'b0;
            if ({1'b0, req_midi_channel} < 5'(MIDI_CHANNELS)) begin
               if (req_mode == MODE_PEDAL)
                  pedal_ff[req_midi_channel[CHW-1:0]] <= req_value >= PEDAL_LEVEL;
               if (req_mode == MODE_MODULATE)
                  wantv_ff[req_midi_channel[CHW-1:0]] <= req_value >= VIBRATO_LEVEL;
            end
         end

         if (cmd.scan) begin
            idx_ff <= idx_ff + 1'b1;
            if (do_free) begin
               free_ff[idx_ff] <= 1'b1;
               sec_ff[idx_ff]  <= 1'b0;
               sus_ff[idx_ff]  <= 1'b0;
               vib_ff[idx_ff]  <= 1'b0;
            end
            if (do_sus)   sus_ff[idx_ff]  <= 1'b1;
            if (do_stamp) time_ff[idx_ff] <= now_ff;
            if (do_vib)   vib_ff[idx_ff]  <= vib_on_ff;
            if (match) begin
               if (pend_v_ff) begin
                  rsp_voice_ff <= 5'(pend_voice_ff);
                  rsp_ev_ff    <= pend_ev_ff;
                  rsp_last_ff  <= 1'b0;
               end
               pend_v_ff     <= 1'b1;
               pend_voice_ff <= idx_ff;
               pend_ev_ff    <= ev;
            end
         end

         if (cmd.search) begin
            ptr_ff <= nxt;
            idx_ff <= cmd.clear_idx ? '0 : idx_ff + 1'b1;
            if (free_ff[nxt]) sel_ff <= nxt;
         end

         if (cmd.steal) begin
            idx_ff    <= idx_ff + 1'b1;
            stolen_ff <= 1'b1;
            if (sec_ff[idx_ff]) sel_ff <= idx_ff;
            else if (cand) begin
               sel_ff      <= idx_ff;
               old_time_ff <= time_ff[idx_ff];
               have_old_ff <= 1'b1;
            end
         end

         if (cmd.alloc) begin
            free_ff[sel_ff]  <= 1'b0;
            sus_ff[sel_ff]   <= 1'b0;
            sec_ff[sel_ff]   <= rsec_ff;
            vib_ff[sel_ff]   <= wantv_ff[chi];
            owner_ff[sel_ff] <= ch_ff;
            note_ff[sel_ff]  <= rnote_ff;
            time_ff[sel_ff]  <= now_ff;
            rsp_voice_ff     <= 5'(sel_ff);
            rsp_ev_ff        <= stolen_ff ? EV_ALLOC_STOLEN : EV_ALLOC_FREE;
            rsp_last_ff      <= 1'b1;
         end

         if (cmd.finish) begin
            rsp_last_ff  <= 1'b1;
            rsp_voice_ff <= pend_v_ff ? 5'(pend_voice_ff) : 5'd0;
            rsp_ev_ff    <= pend_v_ff ? pend_ev_ff : EV_NONE;
            pend_v_ff    <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_voice     = rsp_voice_ff;
   assign rsp_event_res = rsp_ev_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- hw/rtl/synth_voice_allocator.sv -----
// Voice allocator top level: sequencer plus voice table datapath.
// Each request walks the voices in use one voice per cycle: allocate searches
// for a free voice and may then steal one, other modes scan; the last
// result is on the ports in the first cycle with busy low, and the next
// request is taken in that cycle. One request at a time.
// Synchronous reset restores the voice table, channel flags and count 9.
// Results are strobed for one cycle; the receiver cannot stall.
module synth_voice_allocator #(
   parameter int MAX_VOICES    = sva_pkg::MAX_VOICES_DEF,
   parameter int MIDI_CHANNELS = sva_pkg::MIDI_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [3:0]  req_midi_channel,
   input  logic [6:0]  req_note,
   input  logic        req_secondary,
   input  logic        req_no_search_past_free,
   input  logic        req_no_kill_oldest,
   input  logic [6:0]  req_value,
   input  logic [31:0] req_now,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_voice_count,
   output logic        rsp_valid,
   output logic [4:0]  rsp_voice,
   output logic [2:0]  rsp_event_res,
   output logic        rsp_last
);
   import sva_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   sva_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   sva_dp #(
      .MAX_VOICES    (MAX_VOICES),
      .MIDI_CHANNELS (MIDI_CHANNELS)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_mode                (req_mode),
      .req_midi_channel        (req_midi_channel),
      .req_note                (req_note),
      .req_secondary           (req_secondary),
      .req_no_search_past_free (req_no_search_past_free),
      .req_no_kill_oldest      (req_no_kill_oldest),
      .req_value               (req_value),
      .req_now                 (req_now),
      .csr_valid               (csr_valid & csr_ready),
      .csr_voice_count         (csr_voice_count),
      .rsp_valid               (rsp_valid),
      .rsp_voice               (rsp_voice),
      .rsp_event_res           (rsp_event_res),
      .rsp_last                (rsp_last)
   );

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request accepted but block not busy");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid) else $error("result right after last");

   a_none_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_NONE |-> rsp_last && rsp_voice == 5'd0)
      else $error("empty result malformed");

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for synth_voice_allocator: random and directed voice requests,
// checked against a scoreboard class that predicts the voice table.
// Depends on sva_pkg and the synth_voice_allocator RTL.
module tb;
   import sva_pkg::*;

   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   typedef struct {
      logic [2:0]  mode;
      logic [3:0]  midi_channel;
      logic [6:0]  note;
      logic        secondary;
      logic        no_search_past_free;
      logic        no_kill_oldest;
      logic [6:0]  value;
      logic [31:0] now;
   } voice_req_type;

   typedef struct {
      logic [4:0] voice;
      logic [2:0] event_res;
      logic       last;
   } voice_rsp_type;

   class voice_table_scoreboard;
      bit         is_free [MAX_VOICES_DEF];
      bit         is_sec  [MAX_VOICES_DEF];
      bit         is_sus  [MAX_VOICES_DEF];
      bit         is_vib  [MAX_VOICES_DEF];
      bit [3:0]   owner   [MAX_VOICES_DEF];
      bit [6:0]   held_note[MAX_VOICES_DEF];
      bit [31:0]  stamp   [MAX_VOICES_DEF];
      bit [4:0]   search_ptr;
      bit         pedal_on [MIDI_CHANNELS_DEF];
      bit         vib_want [MIDI_CHANNELS_DEF];
      bit [4:0]   voice_count;
      voice_rsp_type due[$];
      int         errors;

      function new();
         for (int i = 0; i < MAX_VOICES_DEF; i++) begin
            is_free[i] = 1'b1; is_sec[i] = 1'b1; is_sus[i] = 1'b1; is_vib[i] = 1'b1;
            owner[i] = 4'hF; held_note[i] = 7'h7F; stamp[i] = '1;
         end
         for (int c = 0; c < MIDI_CHANNELS_DEF; c++) begin
            pedal_on[c] = 1'b0; vib_want[c] = 1'b0;
         end
         search_ptr = 5'(MAX_VOICES_DEF - 1);
         voice_count = VOICE_COUNT_RESET;
         errors = 0;
      endfunction

      function int voices_used();
         int n;
         n = voice_count;
         if (n == 0) n = 1;
         if (n > MAX_VOICES_DEF) n = MAX_VOICES_DEF;
         return n;
      endfunction

      function void release_voice(int v);
         is_free[v] = 1'b1; is_sec[v] = 1'b0; is_sus[v] = 1'b0; is_vib[v] = 1'b0;
      endfunction

      function int pick_voice(bit no_steal, bit no_oldest, bit [31:0] now,
                              output bit stolen);
         int n;
         int nxt;
         bit have_old;
         int oldest;
         bit [31:0] old_time;
         n = voices_used();
         have_old = 1'b0;
         oldest = 0;
         old_time = now;
         stolen = 1'b0;
         for (int i = 0; i < n; i++) begin
            nxt = search_ptr + 1;
            if (nxt >= n) nxt = 0;
            search_ptr = 5'(nxt);
            if (is_free[nxt]) return nxt;
         end
         if (no_steal) return -1;
         for (int i = 0; i < n; i++) begin
            if (is_sec[i]) begin
               release_voice(i);
               stolen = 1'b1;
               return i;
            end
            if (stamp[i] < old_time) begin
               old_time = stamp[i];
               oldest = i;
               have_old = 1'b1;
            end
         end
         if (!no_oldest && have_old) begin
            release_voice(oldest);
            stolen = 1'b1;
            return oldest;
         end
         return -1;
      endfunction

      function void note_request(voice_req_type r);
         voice_rsp_type got[$];
         voice_rsp_type one;
         int n;
         int v;
         bit stolen;
         bit on;
         int ch;
         n = voices_used();
         ch = r.midi_channel;
         one.last = 1'b0;
         if (r.mode == MODE_STOP_ALL) begin
            for (int i = 0; i < n; i++)
               if (!is_free[i]) begin
                  release_voice(i);
                  one.voice = 5'(i); one.event_res = EV_RELEASED; got.push_back(one);
               end
         end else if (r.mode == MODE_ALLOC) begin
            v = pick_voice(r.no_search_past_free, r.no_kill_oldest, r.now, stolen);
            if (v >= 0) begin
               is_free[v] = 1'b0; is_sus[v] = 1'b0; is_sec[v] = r.secondary;
               is_vib[v] = vib_want[ch]; owner[v] = r.midi_channel;
               held_note[v] = r.note; stamp[v] = r.now;
               one.voice = 5'(v);
               one.event_res = stolen ? EV_ALLOC_STOLEN : EV_ALLOC_FREE;
               got.push_back(one);
            end
         end else if (r.mode == MODE_RELEASE) begin
            for (int i = 0; i < n; i++)
               if (!is_free[i] && owner[i] == r.midi_channel && held_note[i] == r.note) begin
                  one.voice = 5'(i);
                  if (pedal_on[ch]) begin
                     is_sus[i] = 1'b1; one.event_res = EV_SUSTAINED;
                  end else begin
                     release_voice(i); one.event_res = EV_RELEASED;
                  end
                  got.push_back(one);
               end
         end else if (r.mode == MODE_PEDAL) begin
            pedal_on[ch] = r.value >= PEDAL_LEVEL;
            if (!pedal_on[ch])
               for (int i = 0; i < n; i++)
                  if (!is_free[i] && owner[i] == r.midi_channel && is_sus[i]) begin
                     release_voice(i);
                     one.voice = 5'(i); one.event_res = EV_RELEASED; got.push_back(one);
                  end
         end else if (r.mode == MODE_MODULATE) begin
            on = r.value >= VIBRATO_LEVEL;
            vib_want[ch] = on;
            for (int i = 0; i < n; i++)
               if (!is_free[i] && owner[i] == r.midi_channel) begin
                  stamp[i] = r.now;
                  if (is_vib[i] != on) begin
                     is_vib[i] = on;
                     one.voice = 5'(i);
                     one.event_res = on ? EV_VIB_ON : EV_VIB_OFF;
                     got.push_back(one);
                  end
               end
         end else if (r.mode == MODE_TOUCH) begin
            for (int i = 0; i < n; i++)
               if (!is_free[i] && owner[i] == r.midi_channel) begin
                  stamp[i] = r.now;
                  one.voice = 5'(i); one.event_res = EV_TOUCHED; got.push_back(one);
               end
         end
         if (got.size() == 0) begin
            one.voice = 5'd0; one.event_res = EV_NONE; got.push_back(one);
         end
         got[got.size() - 1].last = 1'b1;
         foreach (got[k]) due.push_back(got[k]);
      endfunction

      function void check_result(logic [4:0] voice, logic [2:0] event_res, logic last);
         voice_rsp_type exp_rsp;
         if (due.size() == 0) begin
            $error("unexpected result: voice %0d event %0d last %0d", voice, event_res, last);
            errors++;
            return;
         end
         exp_rsp = due.pop_front();
         if (voice !== exp_rsp.voice) begin
            $error("voice: expected %0d, actual %0d", exp_rsp.voice, voice);
            errors++;
         end
         if (event_res !== exp_rsp.event_res) begin
            $error("event_res: expected %0d, actual %0d", exp_rsp.event_res, event_res);
            errors++;
         end
         if (last !== exp_rsp.last) begin
            $error("last: expected %0d, actual %0d", exp_rsp.last, last);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 50;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   voice_req_type cur = '{default: '0};
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [4:0]  csr_voice_count = '0;
   logic        rsp_valid;
   logic [4:0]  rsp_voice;
   logic [2:0]  rsp_event_res;
   logic        rsp_last;

   voice_table_scoreboard sb = new();
   int          stall_cycles = 0;
   bit          quiet = 0;
   bit [31:0]   play_clock = 32'd1000;

   synth_voice_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(cur.mode), .req_midi_channel(cur.midi_channel), .req_note(cur.note),
      .req_secondary(cur.secondary), .req_no_search_past_free(cur.no_search_past_free),
      .req_no_kill_oldest(cur.no_kill_oldest), .req_value(cur.value), .req_now(cur.now),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_voice_count(csr_voice_count),
      .rsp_valid(rsp_valid), .rsp_voice(rsp_voice), .rsp_event_res(rsp_event_res),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.voice_count = csr_voice_count;
         if (start && !busy)
            sb.note_request(cur);
         if (rsp_valid)
            sb.check_result(rsp_voice, rsp_event_res, rsp_last);
         if ((csr_valid && csr_ready) || (start && !busy) || rsp_valid)
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_request(voice_req_type r);
      logic was_busy;
      cur = r;
      start = 1;
      forever begin
         was_busy = busy;
         @(posedge clock);
         if (!was_busy) break;
         @(negedge clock);
      end
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start = 0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic drain();
      start = 0;
      while (sb.due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_voice_count(logic [4:0] count);
      logic was_ready;
      drain();
      csr_voice_count = count;
      csr_valid = 1;
      forever begin
         was_ready = csr_ready;
         @(posedge clock);
         if (was_ready) break;
         @(negedge clock);
      end
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic voice_req_type make_req(logic [2:0] mode, logic [3:0] ch,
                                              logic [6:0] nt, logic [6:0] val,
                                              logic [31:0] now, logic sec = 1'b0,
                                              logic no_steal = 1'b0,
                                              logic no_oldest = 1'b0);
      voice_req_type r;
      r.mode = mode; r.midi_channel = ch; r.note = nt; r.value = val; r.now = now;
      r.secondary = sec; r.no_search_past_free = no_steal; r.no_kill_oldest = no_oldest;
      return r;
   endfunction

   function automatic voice_req_type random_req();
      voice_req_type r;
      int pick;
      r.midi_channel = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
      r.note = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(60, 63));
      r.value = ($urandom_range(0, 1) == 0) ? 7'($urandom) : 7'($urandom_range(38, 66));
      r.secondary = ($urandom_range(0, 3) == 0);
      r.no_search_past_free = ($urandom_range(0, 5) == 0);
      r.no_kill_oldest = ($urandom_range(0, 4) == 0);
      play_clock += $urandom_range(0, 40);
      pick = $urandom_range(0, 19);
      r.now = (pick == 0) ? $urandom : (pick == 1) ? 32'd0 : (pick == 2) ? '1 : play_clock;
      pick = $urandom_range(0, 99);
      if (pick < 38)      r.mode = MODE_ALLOC;
      else if (pick < 60) r.mode = MODE_RELEASE;
      else if (pick < 70) r.mode = MODE_PEDAL;
      else if (pick < 80) r.mode = MODE_MODULATE;
      else if (pick < 88) r.mode = MODE_TOUCH;
      else if (pick < 92) r.mode = MODE_STOP_ALL;
      else                r.mode = 3'($urandom);
      return r;
   endfunction

   initial begin
      logic [4:0] counts[7];
      counts = '{5'd9, 5'd1, 5'd18, 5'd0, 5'd31, 5'd5, 5'd2};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      for (int i = 0; i < 9; i++)
         send_request(make_req(MODE_ALLOC, 4'(i % 3), 7'(60 + i), 7'd0, 32'(10 + i),
                               i == 4));
      send_request(make_req(MODE_ALLOC, 4'd0, 7'd70, 7'd0, 32'd100, 1'b0, 1'b1, 1'b0));
      send_request(make_req(MODE_ALLOC, 4'd1, 7'd71, 7'd0, 32'd101, 1'b0, 1'b0, 1'b1));
      send_request(make_req(MODE_ALLOC, 4'd2, 7'd72, 7'd0, 32'd5, 1'b0, 1'b0, 1'b1));
      send_request(make_req(MODE_ALLOC, 4'd15, 7'd127, 7'd0, '1, 1'b0, 1'b0, 1'b0));
      send_request(make_req(MODE_ALLOC, 4'd3, 7'd0, 7'd0, 32'd0, 1'b0, 1'b0, 1'b0));
      send_request(make_req(MODE_MODULATE, 4'd0, 7'd0, 7'd40, 32'd200));
      send_request(make_req(MODE_MODULATE, 4'd0, 7'd0, 7'd39, 32'd201));
      send_request(make_req(MODE_MODULATE, 4'd1, 7'd0, 7'd127, 32'd202));
      send_request(make_req(MODE_PEDAL, 4'd1, 7'd0, 7'h40, 32'd203));
      send_request(make_req(MODE_RELEASE, 4'd1, 7'd61, 7'd0, 32'd204));
      send_request(make_req(MODE_PEDAL, 4'd1, 7'd0, 7'h3F, 32'd205));
      send_request(make_req(MODE_TOUCH, 4'd2, 7'd0, 7'd0, 32'd206));
      send_request(make_req(MODE_SPARE_A, 4'd0, 7'd60, 7'd0, 32'd207));
      send_request(make_req(MODE_SPARE_B, 4'd0, 7'd60, 7'd0, 32'd208));
      send_request(make_req(MODE_STOP_ALL, 4'd0, 7'd0, 7'd0, 32'd209));
      send_request(make_req(MODE_RELEASE, 4'd0, 7'd60, 7'd0, 32'd210));

      foreach (counts[p]) begin
         write_voice_count(counts[p]);
         quiet = (p == 6);
         for (int i = 0; i < 56; i++) begin
            if (i == 28) drain();
            send_request(random_req());
         end
      end

      drain();
      if (sb.errors == 0 && sb.due.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/sva_pkg.sv
hw/rtl/sva_ctrl.sv
hw/rtl/sva_dp.sv
hw/rtl/synth_voice_allocator.sv
tb/sv/tb.sv
